FILE: sv/i2cee_pkg.sv
// Shared types, codes and helper functions of the I2C EEPROM transfer sequencer.
package i2cee_pkg;

   // Default width of the EEPROM memory address.
   localparam int ADDR_BITS_DEF = 16;

   // Fixed field widths.
   localparam int MEM_ADDR_W  = 16;
   localparam int PAGE_W      = 9;
   localparam int LIMIT_W     = 17;
   localparam int NEXT_ADDR_W = 17;
   localparam int BYTE_W      = 8;

   // Stream and channel widths; the tdata payloads are padded to whole bytes.
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0]  DEV_ADDR_RST   = 8'hA0;
   localparam logic [PAGE_W-1:0]  PAGE_SIZE_RST  = 9'd64;
   localparam logic [LIMIT_W-1:0] READ_LIMIT_RST = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEV_ADDR   = 2'd0,
      CSR_PAGE_SIZE  = 2'd1,
      CSR_READ_LIMIT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_MASTER = 2'd1,
      ACT_SLAVE  = 2'd2,
      ACT_BUSERR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_VERIFY = 2'd2,
      MODE_BAD    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_ADDR      = 3'd1,
      CMD_DATA      = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_ACK_NEXT  = 3'd4,
      CMD_NACK_STOP = 3'd5,
      CMD_CLEAR     = 3'd6,
      CMD_RSVD      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_BUSY     = 2'd0,
      STAT_DONE     = 2'd1,
      STAT_XFER_ERR = 2'd2,
      STAT_CMP_ERR  = 2'd3
   } status_type;

   // Transfer phase, one-hot.
   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_START    = 8'b0000_0010,
      PH_ADDR_HI  = 8'b0000_0100,
      PH_ADDR_LO  = 8'b0000_1000,
      PH_WRITE    = 8'b0001_0000,
      PH_READ     = 8'b0010_0000,
      PH_ERR_XFER = 8'b0100_0000,
      PH_ERR_CMP  = 8'b1000_0000
   } phase_type;

   // Sequencer state of the top level, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_APPLY = 3'b100
   } seq_state_type;

   // Request tdata fields, last field in the lowest bits.
   typedef struct packed {
      logic [BYTE_W-1:0]     tx_byte;
      logic                  tx_avail;
      logic [BYTE_W-1:0]     rx_byte;
      logic                  rx_nack;
      logic                  arb_lost;
      logic [1:0]            mode;
      logic [MEM_ADDR_W-1:0] mem_addr;
   } req_data_type;

   localparam int REQ_FIELDS_W = $bits(req_data_type);

   // Status of the remainder unit.
   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

   // A page size of zero behaves as one byte per page.
   function automatic logic [PAGE_W-1:0] eff_page(input logic [PAGE_W-1:0] size);
      eff_page = (size == '0) ? PAGE_W'(1) : size;
   endfunction

endpackage

FILE: sv/i2cee_rem_unit.sv
// Bit-serial restoring remainder unit: address modulo page size, one bit per cycle.
module i2cee_rem_unit #(
   parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ADDR_BITS-1:0]         dividend,
   input  logic [i2cee_pkg::PAGE_W-1:0] divisor,
   output i2cee_pkg::rem_stat_type      stat,
   output logic [i2cee_pkg::PAGE_W-1:0] rem
);
   import i2cee_pkg::*;

   localparam int CNT_W = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] dvd_ff, dvd_in;
   logic [PAGE_W-1:0]    dvs_ff, dvs_in;
   logic [PAGE_W-1:0]    rem_ff, rem_in;
   logic [PAGE_W:0]      trial;

   // The partial remainder stays below the divisor, so the trial value fits one extra bit.
   assign trial = {rem_ff, dvd_ff[ADDR_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = PAGE_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[PAGE_W-1:0];
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || done_ff) |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder done while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("remainder unit did not start");

endmodule

FILE: sv/i2c_eeprom_transfer_sequencer.sv
// Top level of the I2C EEPROM transfer sequencer: event decoding, transfer state and result register.
//
// Usage: each bus event (start, master-on-bus, slave-on-bus, bus error) is offered as one
// transaction on the req_ stream, the action code in req_tuser and the other fields in
// req_tdata. Every accepted transaction yields exactly one result transaction on the rsp_
// stream: the bus command in rsp_tuser and its byte, buffer handshakes, status and the next
// page address in rsp_tdata. Configuration (device address, page size, read limit) is written
// through the csr_ channel, which is always ready, and is meant to be changed only while idle.
// A request passes through the CALC and APPLY states before its result is registered. The
// block handles one transaction at a time and takes no new one until that result is committed;
// the pace is set by the bit-serial remainder unit that works out the distance to the page
// boundary, one address bit per cycle.
// Reset is synchronous and active high; it returns the registers to their defaults and the
// transfer to the idle (done) phase with a cleared address and counters.
// If the receiver stalls rsp_tready, the finished result waits in the output register and the
// block holds its computed update until the slot frees, so req_tready stays low meanwhile.
module i2c_eeprom_transfer_sequencer #(
   parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tuser: action[1:0]
   input  logic [i2cee_pkg::REQ_USER_W-1:0] req_tuser,
   // tdata: mem_addr[15:0], mode[17:16], arb_lost[18], rx_nack[19], rx_byte[27:20],
   //        tx_avail[28], tx_byte[36:29], zero padding[39:37]
   input  logic [i2cee_pkg::REQ_DATA_W-1:0] req_tdata,
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tuser: bus_cmd[2:0]
   output logic [i2cee_pkg::RSP_USER_W-1:0] rsp_tuser,
   // tdata: out_byte[7:0], take_byte[8], store_valid[9], store_byte[17:10], status[19:18],
   //        next_addr[36:20], zero padding[39:37]
   output logic [i2cee_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [i2cee_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cee_pkg::CSR_DATA_W-1:0] csr_data
);
   import i2cee_pkg::*;

   // Configuration registers.
   logic [BYTE_W-1:0]  dev_addr_ff;
   logic [PAGE_W-1:0]  page_size_ff;
   logic [LIMIT_W-1:0] read_limit_ff;

   // Transfer state.
   phase_type            phase_ff, phase_in;
   logic [ADDR_BITS-1:0] cur_addr_ff, cur_addr_in;
   logic [PAGE_W-1:0]    page_left_ff, page_left_in;
   logic                 write_dir_ff, write_dir_in;
   logic                 verify_ff, verify_in;
   logic [LIMIT_W-1:0]   stored_cnt_ff, stored_cnt_in;

   // Sequencer and latched request.
   seq_state_type    st_ff, st_in;
   action_type       act_ff;
   req_data_type     item_ff;
   req_data_type     req_item;
   logic             req_fire;
   logic             apply_fire;
   logic             is_start_new;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Remainder unit.
   rem_stat_type         rem_stat;
   logic [PAGE_W-1:0]    rem_val;
   logic [ADDR_BITS-1:0] rem_operand;

   // Step results.
   cmd_type             cmd;
   logic [BYTE_W-1:0]   obyte;
   logic                take;
   logic                sval;
   logic [BYTE_W-1:0]   sbyte;
   status_type          status;
   logic [NEXT_ADDR_W-1:0] naddr;
   logic [PAGE_W-1:0]   page_eff;
   logic [PAGE_W-1:0]   to_bound;
   logic [MEM_ADDR_W-1:0] cur_addr16;

   assign req_item   = req_data_type'(req_tdata[REQ_FIELDS_W-1:0]);
   assign req_tready = (st_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign apply_fire = (st_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // A start with a valid mode brings in a new address; every other item keeps the current one.
   assign is_start_new = (action_type'(req_tuser) == ACT_START)
                         && (mode_type'(req_item.mode) != MODE_BAD);
   assign rem_operand  = is_start_new ? req_item.mem_addr[ADDR_BITS-1:0] : cur_addr_ff;

   i2cee_rem_unit #(
      .ADDR_BITS (ADDR_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (rem_operand),
      .divisor  (eff_page(page_size_ff)),
      .stat     (rem_stat),
      .rem      (rem_val)
   );

   // Bytes from the relevant address to the end of its page.
   assign page_eff = eff_page(page_size_ff);
   assign to_bound = page_eff - rem_val;

   // Sequencer: wait for an item, let the remainder finish, then commit once the output is free.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (req_fire) st_in = ST_CALC;
         ST_CALC:  if (rem_stat.done) st_in = ST_APPLY;
         ST_APPLY: if (apply_fire) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // Transfer step for the latched item.
   always_comb begin
      cmd           = CMD_NONE;
      obyte         = '0;
      take          = 1'b0;
      sval          = 1'b0;
      sbyte         = '0;
      phase_in      = phase_ff;
      cur_addr_in   = cur_addr_ff;
      page_left_in  = page_left_ff;
      write_dir_in  = write_dir_ff;
      verify_in     = verify_ff;
      stored_cnt_in = stored_cnt_ff;
      cur_addr16    = MEM_ADDR_W'(cur_addr_ff);

      unique case (act_ff)
         ACT_START: begin
            // An unknown mode leaves everything as it was.
            if (mode_type'(item_ff.mode) != MODE_BAD) begin
               cur_addr_in   = item_ff.mem_addr[ADDR_BITS-1:0];
               write_dir_in  = (mode_type'(item_ff.mode) == MODE_WRITE);
               verify_in     = (mode_type'(item_ff.mode) == MODE_VERIFY);
               page_left_in  = (mode_type'(item_ff.mode) == MODE_WRITE) ? to_bound : '0;
               stored_cnt_in = '0;
               phase_in      = PH_START;
               cmd           = CMD_ADDR;
               obyte         = dev_addr_ff;
            end
         end
         ACT_MASTER: begin
            if (item_ff.arb_lost || item_ff.rx_nack) begin
               phase_in = PH_ERR_XFER;
               cmd      = CMD_STOP;
            end else begin
               unique case (phase_ff)
                  PH_START: begin
                     phase_in = PH_ADDR_HI;
                     cmd      = CMD_DATA;
                     obyte    = cur_addr16[15:8];
                  end
                  PH_ADDR_HI: begin
                     phase_in = PH_ADDR_LO;
                     cmd      = CMD_DATA;
                     obyte    = cur_addr16[7:0];
                  end
                  PH_ADDR_LO: begin
                     if (write_dir_ff) begin
                        phase_in = PH_WRITE;
                     end else begin
                        // Repeated start with the read address.
                        phase_in = PH_READ;
                        cmd      = CMD_ADDR;
                        obyte    = dev_addr_ff + BYTE_W'(1);
                     end
                  end
                  PH_WRITE: begin
                     if ((page_left_ff != '0) && item_ff.tx_avail) begin
                        page_left_in = page_left_ff - PAGE_W'(1);
                        cmd          = CMD_DATA;
                        obyte        = item_ff.tx_byte;
                        take         = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                        cmd      = CMD_STOP;
                     end
                  end
                  default: cmd = CMD_CLEAR;
               endcase
            end
         end
         ACT_SLAVE: begin
            if (phase_ff != PH_READ) begin
               cmd = CMD_CLEAR;
            end else if (item_ff.rx_nack) begin
               phase_in = PH_IDLE;
               cmd      = CMD_STOP;
            end else if (verify_ff) begin
               if (!item_ff.tx_avail) begin
                  // Source used up: the verify ends cleanly.
                  phase_in = PH_IDLE;
                  cmd      = CMD_NACK_STOP;
               end else begin
                  take = 1'b1;
                  if (item_ff.tx_byte != item_ff.rx_byte) begin
                     phase_in = PH_ERR_CMP;
                     cmd      = CMD_NACK_STOP;
                  end else begin
                     cmd = CMD_ACK_NEXT;
                  end
               end
            end else if (stored_cnt_ff >= read_limit_ff) begin
               phase_in = PH_IDLE;
               cmd      = CMD_NACK_STOP;
            end else begin
               stored_cnt_in = stored_cnt_ff + LIMIT_W'(1);
               sval          = 1'b1;
               sbyte         = item_ff.rx_byte;
               cmd           = CMD_ACK_NEXT;
            end
         end
         default: begin
            // Bus error aborts whatever is running.
            phase_in = PH_ERR_XFER;
            cmd      = CMD_CLEAR;
         end
      endcase

      unique case (phase_in)
         PH_IDLE:     status = STAT_DONE;
         PH_ERR_XFER: status = STAT_XFER_ERR;
         PH_ERR_CMP:  status = STAT_CMP_ERR;
         default:     status = STAT_BUSY;
      endcase

      // A finished write reports the address after its page chunk.
      if ((phase_in == PH_IDLE) && write_dir_in) begin
         naddr = NEXT_ADDR_W'(MEM_ADDR_W'(cur_addr_in)) + NEXT_ADDR_W'(to_bound);
      end else begin
         naddr = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         dev_addr_ff   <= DEV_ADDR_RST;
         page_size_ff  <= PAGE_SIZE_RST;
         read_limit_ff <= READ_LIMIT_RST;
         phase_ff      <= PH_IDLE;
         cur_addr_ff   <= '0;
         page_left_ff  <= '0;
         write_dir_ff  <= 1'b0;
         verify_ff     <= 1'b0;
         stored_cnt_ff <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_idx_type'(csr_index))
               CSR_DEV_ADDR:   dev_addr_ff   <= csr_data[BYTE_W-1:0];
               CSR_PAGE_SIZE:  page_size_ff  <= csr_data[PAGE_W-1:0];
               CSR_READ_LIMIT: read_limit_ff <= csr_data[LIMIT_W-1:0];
               default:        ;
            endcase
         end
         if (apply_fire) begin
            phase_ff      <= phase_in;
            cur_addr_ff   <= cur_addr_in;
            page_left_ff  <= page_left_in;
            write_dir_ff  <= write_dir_in;
            verify_ff     <= verify_in;
            stored_cnt_ff <= stored_cnt_in;
         end
      end
      if (req_fire) begin
         act_ff  <= action_type'(req_tuser);
         item_ff <= req_item;
      end
      if (apply_fire) begin
         rsp_user_ff <= cmd;
         rsp_data_ff <= {3'b000, naddr, status, sbyte, sval, take, obyte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_calc_has_unit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CALC) |-> (rem_stat.busy || rem_stat.done))
      else $error("sequencer waits on an idle remainder unit");

   a_store_only_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[9]) |-> (rsp_data_ff[19:18] == STAT_BUSY))
      else $error("stored byte reported outside a running read");

   a_naddr_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[36:20] != '0)) |-> (rsp_data_ff[19:18] == STAT_DONE))
      else $error("next address reported while not done");

endmodule

FILE: tb/tb_i2c_eeprom_transfer_sequencer.sv
// Self-checking testbench for the I2C EEPROM transfer sequencer: directed table, then random transfers.
module tb_i2c_eeprom_transfer_sequencer;
   import i2cee_pkg::*;

   localparam int ADDR_BITS = 16;
   // This pause covers the time from acceptance to result, with margin.
   localparam int SETTLE_CYCLES = ADDR_BITS + 8;
   // A correct run never goes this long without a transaction on some channel: one item, a
   // sender gap and a receiver stall are each far shorter, and a register change only waits
   // for the block to drain and for the settle pause.
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_SETTINGS = 10;
   localparam int EVENTS_PER_SETTING = 110;

   // One bus event as the block sees it.
   typedef struct packed {
      action_type            action;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [1:0]            mode;
      logic                  arb_lost;
      logic                  rx_nack;
      logic [BYTE_W-1:0]     rx_byte;
      logic                  tx_avail;
      logic [BYTE_W-1:0]     tx_byte;
   } bus_event_type;

   // One bus command with its side information.
   typedef struct packed {
      cmd_type                cmd;
      logic [BYTE_W-1:0]      out_byte;
      logic                   take_byte;
      logic                   store_valid;
      logic [BYTE_W-1:0]      store_byte;
      status_type             status;
      logic [NEXT_ADDR_W-1:0] next_addr;
   } bus_reply_type;

   typedef struct {
      bus_event_type ev;
      bit            fixed;
      bus_reply_type reply;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow of the block's registers and transfer state, advanced on every accepted event.
   logic [BYTE_W-1:0]     cfg_dev;
   logic [PAGE_W-1:0]     cfg_page;
   logic [LIMIT_W-1:0]    cfg_limit;
   phase_type             ee_phase;
   logic [MEM_ADDR_W-1:0] ee_addr;
   logic [9:0]            ee_left;
   logic                  ee_is_write;
   logic                  ee_is_verify;
   logic [LIMIT_W-1:0]    ee_stored;

   bus_reply_type  due_replies[$];
   table_row_type  directed_rows[$];

   bit idle_on = 1'b1;
   int fail_count = 0;
   int checked_count = 0;
   int event_count = 0;
   int quiet_cycles = 0;
   int write_count = 0;
   int read_count = 0;
   int verify_count = 0;

   always #4 clock = ~clock;

   i2c_eeprom_transfer_sequencer #(.ADDR_BITS(ADDR_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Distance from an address to the end of its page; a page size of zero counts as one byte.
   function automatic logic [9:0] bytes_to_page_end(input logic [MEM_ADDR_W-1:0] a);
      logic [9:0] ps;
      ps = (cfg_page == '0) ? 10'd1 : 10'(cfg_page);
      return ps - 10'(a % ps);
   endfunction

   // Works out the command that one bus event should produce and advances the shadow state.
   function automatic bus_reply_type sequencer_reply(input bus_event_type ev);
      bus_reply_type r;
      r = '0;
      r.cmd = CMD_NONE;
      case (ev.action)
         ACT_START: begin
            if (ev.mode != MODE_BAD) begin
               ee_addr      = ev.mem_addr & 16'((32'd1 << ADDR_BITS) - 1);
               ee_is_write  = (ev.mode == MODE_WRITE);
               ee_is_verify = (ev.mode == MODE_VERIFY);
               ee_left      = ee_is_write ? bytes_to_page_end(ee_addr) : 10'd0;
               ee_stored    = '0;
               ee_phase     = PH_START;
               r.cmd        = CMD_ADDR;
               r.out_byte   = cfg_dev;
            end
         end
         ACT_MASTER: begin
            if (ev.arb_lost || ev.rx_nack) begin
               ee_phase = PH_ERR_XFER;
               r.cmd    = CMD_STOP;
            end else begin
               case (ee_phase)
                  PH_START: begin
                     ee_phase   = PH_ADDR_HI;
                     r.cmd      = CMD_DATA;
                     r.out_byte = ee_addr[15:8];
                  end
                  PH_ADDR_HI: begin
                     ee_phase   = PH_ADDR_LO;
                     r.cmd      = CMD_DATA;
                     r.out_byte = ee_addr[7:0];
                  end
                  PH_ADDR_LO: begin
                     if (ee_is_write) begin
                        ee_phase = PH_WRITE;
                     end else begin
                        ee_phase   = PH_READ;
                        r.cmd      = CMD_ADDR;
                        r.out_byte = cfg_dev + 8'd1;
                     end
                  end
                  PH_WRITE: begin
                     if (ee_left != 0 && ev.tx_avail) begin
                        ee_left     = ee_left - 10'd1;
                        r.cmd       = CMD_DATA;
                        r.out_byte  = ev.tx_byte;
                        r.take_byte = 1'b1;
                     end else begin
                        ee_phase = PH_IDLE;
                        r.cmd    = CMD_STOP;
                     end
                  end
                  default: r.cmd = CMD_CLEAR;
               endcase
            end
         end
         ACT_SLAVE: begin
            if (ee_phase != PH_READ) begin
               r.cmd = CMD_CLEAR;
            end else if (ev.rx_nack) begin
               ee_phase = PH_IDLE;
               r.cmd    = CMD_STOP;
            end else if (ee_is_verify) begin
               if (!ev.tx_avail) begin
                  ee_phase = PH_IDLE;
                  r.cmd    = CMD_NACK_STOP;
               end else begin
                  // The expected byte is used up whether or not it matches.
                  r.take_byte = 1'b1;
                  if (ev.tx_byte != ev.rx_byte) begin
                     ee_phase = PH_ERR_CMP;
                     r.cmd    = CMD_NACK_STOP;
                  end else begin
                     r.cmd = CMD_ACK_NEXT;
                  end
               end
            end else if (ee_stored >= cfg_limit) begin
               ee_phase = PH_IDLE;
               r.cmd    = CMD_NACK_STOP;
            end else begin
               ee_stored     = ee_stored + 1'b1;
               r.store_valid = 1'b1;
               r.store_byte  = ev.rx_byte;
               r.cmd         = CMD_ACK_NEXT;
            end
         end
         default: begin
            ee_phase = PH_ERR_XFER;
            r.cmd    = CMD_CLEAR;
         end
      endcase
      case (ee_phase)
         PH_IDLE:     r.status = STAT_DONE;
         PH_ERR_XFER: r.status = STAT_XFER_ERR;
         PH_ERR_CMP:  r.status = STAT_CMP_ERR;
         default:     r.status = STAT_BUSY;
      endcase
      if (ee_phase == PH_IDLE && ee_is_write)
         r.next_addr = NEXT_ADDR_W'(ee_addr) + NEXT_ADDR_W'(bytes_to_page_end(ee_addr));
      return r;
   endfunction

   function automatic bus_event_type bus_event(input action_type act, input logic [15:0] addr,
                                               input logic [1:0] mode, input logic arb,
                                               input logic nack, input logic [7:0] rx,
                                               input logic avail, input logic [7:0] tx);
      bus_event_type ev;
      ev.action   = act;
      ev.mem_addr = addr;
      ev.mode     = mode;
      ev.arb_lost = arb;
      ev.rx_nack  = nack;
      ev.rx_byte  = rx;
      ev.tx_avail = avail;
      ev.tx_byte  = tx;
      return ev;
   endfunction

   function automatic bus_reply_type reply(input cmd_type cmd, input logic [7:0] ob,
                                           input logic take, input logic sv,
                                           input logic [7:0] sb, input status_type st,
                                           input logic [16:0] na);
      bus_reply_type r;
      r.cmd         = cmd;
      r.out_byte    = ob;
      r.take_byte   = take;
      r.store_valid = sv;
      r.store_byte  = sb;
      r.status      = st;
      r.next_addr   = na;
      return r;
   endfunction

   function automatic void add_row(input bus_event_type ev, input bit fixed,
                                   input bus_reply_type r);
      table_row_type row;
      row.ev    = ev;
      row.fixed = fixed;
      row.reply = r;
      directed_rows.push_back(row);
   endfunction

   // Every field random, the action and mode included.
   function automatic bus_event_type any_event();
      return bus_event(action_type'($urandom_range(0, 3)), 16'($urandom),
                       2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 8'($urandom),
                       1'($urandom), 8'($urandom));
   endfunction

   // Offers one event on the request stream, with an optional random gap before it, and
   // records the reply it is owed once the transaction has been accepted.
   task automatic send_event(input bus_event_type ev, input bit fixed, input bus_reply_type want);
      req_data_type  d;
      bus_reply_type predicted;
      if (idle_on && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      d.mem_addr = ev.mem_addr;
      d.mode     = ev.mode;
      d.arb_lost = ev.arb_lost;
      d.rx_nack  = ev.rx_nack;
      d.rx_byte  = ev.rx_byte;
      d.tx_avail = ev.tx_avail;
      d.tx_byte  = ev.tx_byte;
      req_tvalid <= 1'b1;
      req_tuser  <= ev.action;
      req_tdata  <= REQ_DATA_W'(d);
      do @(posedge clock); while (!req_tready);
      predicted = sequencer_reply(ev);
      due_replies.push_back(fixed ? want : predicted);
      if (!(ev.action == ACT_START && ev.mode == MODE_BAD))
         event_count++;
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEV_ADDR:   cfg_dev = val[BYTE_W-1:0];
         CSR_PAGE_SIZE:  cfg_page = val[PAGE_W-1:0];
         CSR_READ_LIMIT: cfg_limit = val;
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result side: compare every accepted result transaction with the oldest reply owed.
   always @(posedge clock) begin : reply_check
      bus_reply_type got;
      bus_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cmd         = cmd_type'(rsp_tuser);
         got.out_byte    = rsp_tdata[7:0];
         got.take_byte   = rsp_tdata[8];
         got.store_valid = rsp_tdata[9];
         got.store_byte  = rsp_tdata[17:10];
         got.status      = status_type'(rsp_tdata[19:18]);
         got.next_addr   = rsp_tdata[36:20];
         if (due_replies.size() == 0) begin
            $error("result transaction with none outstanding: bus_cmd %0d", got.cmd);
            fail_count++;
         end else begin
            want = due_replies.pop_front();
            check_field("bus_cmd", 17'(want.cmd), 17'(got.cmd));
            check_field("out_byte", 17'(want.out_byte), 17'(got.out_byte));
            check_field("take_byte", 17'(want.take_byte), 17'(got.take_byte));
            check_field("store_valid", 17'(want.store_valid), 17'(got.store_valid));
            check_field("store_byte", 17'(want.store_byte), 17'(got.store_byte));
            check_field("status", 17'(want.status), 17'(got.status));
            check_field("next_addr", want.next_addr, got.next_addr);
            checked_count++;
         end
      end
   end

   // Receiver back-pressure: random bursts of stalled cycles while idling is allowed.
   always @(posedge clock) begin : rsp_stall
      int stall_left;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 6) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: any transaction on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("i2c_eeprom_transfer_sequencer verification failed");
         $finish;
      end
   end

   initial begin
      bus_event_type ev;
      bus_reply_type none;
      logic [1:0]    mode;
      int            steps;
      int            target;
      int            pick;

      none = '0;
      cfg_dev      = DEV_ADDR_RST;
      cfg_page     = PAGE_SIZE_RST;
      cfg_limit    = READ_LIMIT_RST;
      ee_phase     = PH_IDLE;
      ee_addr      = '0;
      ee_left      = '0;
      ee_is_write  = 1'b0;
      ee_is_verify = 1'b0;
      ee_stored    = '0;

      // Directed table, run with the reset register values. Rows marked 1 carry a reply that
      // can be read straight off the behaviour; the others take the predicted one.
      // Bus events in the idle phase only clear the flag; an unknown mode is ignored.
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_CLEAR, 8'h00, 0, 0, 8'h00, STAT_DONE, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_CLEAR, 8'h00, 0, 0, 8'h00, STAT_DONE, 17'h0));
      add_row(bus_event(ACT_START, 16'h1234, MODE_BAD, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_NONE, 8'h00, 0, 0, 8'h00, STAT_DONE, 17'h0));
      // Page write at the top address: a single byte fits before the boundary, and the
      // reported next address carries into bit 16.
      add_row(bus_event(ACT_START, 16'hFFFF, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_ADDR, 8'hA0, 0, 0, 8'h00, STAT_BUSY, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_DATA, 8'hFF, 0, 0, 8'h00, STAT_BUSY, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_DATA, 8'hFF, 0, 0, 8'h00, STAT_BUSY, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_NONE, 8'h00, 0, 0, 8'h00, STAT_BUSY, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 1, 8'hFF), 1,
              reply(CMD_DATA, 8'hFF, 1, 0, 8'h00, STAT_BUSY, 17'h0));
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 1, 8'h00), 1,
              reply(CMD_STOP, 8'h00, 0, 0, 8'h00, STAT_DONE, 17'h10000));
      // Plain read from address zero, two bytes kept, ended by the EEPROM's NACK.
      add_row(bus_event(ACT_START, 16'h0000, MODE_READ, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 0, 8'hFF, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 1, 8'h5A, 0, 8'h00), 1,
              reply(CMD_STOP, 8'h00, 0, 0, 8'h00, STAT_DONE, 17'h0));
      // Verify lost to arbitration, then a verify that matches once and then mismatches.
      add_row(bus_event(ACT_START, 16'h1234, MODE_VERIFY, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 1, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_STOP, 8'h00, 0, 0, 8'h00, STAT_XFER_ERR, 17'h0));
      add_row(bus_event(ACT_START, 16'h00FF, MODE_VERIFY, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_MASTER, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 0, none);
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 0, 8'h5A, 1, 8'h5A), 0, none);
      add_row(bus_event(ACT_SLAVE, 16'h0000, MODE_WRITE, 0, 0, 8'hA5, 1, 8'h5A), 1,
              reply(CMD_NACK_STOP, 8'h00, 1, 0, 8'h00, STAT_CMP_ERR, 17'h0));
      add_row(bus_event(ACT_BUSERR, 16'h0000, MODE_WRITE, 0, 0, 8'h00, 0, 8'h00), 1,
              reply(CMD_CLEAR, 8'h00, 0, 0, 8'h00, STAT_XFER_ERR, 17'h0));

      // Reset is held from time zero and released at a clock edge.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_event(directed_rows[i].ev, directed_rows[i].fixed, directed_rows[i].reply);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         // Registers only change once the block has answered everything and gone quiet.
         req_tvalid <= 1'b0;
         while (due_replies.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);

         // The first few settings pin the extremes; later ones favour small pages and limits
         // so that writes reach the page boundary and reads reach the limit often.
         case (s)
            0: begin
               write_reg(CSR_DEV_ADDR, 17'h00);
               write_reg(CSR_PAGE_SIZE, 17'd1);
               write_reg(CSR_READ_LIMIT, 17'd0);
               write_reg(CSR_UNUSED, 17'($urandom));
            end
            1: begin
               write_reg(CSR_DEV_ADDR, 17'hFE);
               write_reg(CSR_PAGE_SIZE, 17'd256);
               write_reg(CSR_READ_LIMIT, 17'd65536);
            end
            2: begin
               write_reg(CSR_DEV_ADDR, 17'hFF);
               write_reg(CSR_PAGE_SIZE, 17'd0);
               write_reg(CSR_READ_LIMIT, 17'd1);
            end
            3: begin
               write_reg(CSR_DEV_ADDR, 17'h50);
               write_reg(CSR_PAGE_SIZE, 17'd16);
               write_reg(CSR_READ_LIMIT, 17'd3);
            end
            default: begin
               write_reg(CSR_DEV_ADDR, 17'($urandom_range(0, 255)));
               pick = $urandom_range(0, 9);
               if (pick < 7)
                  write_reg(CSR_PAGE_SIZE, 17'($urandom_range(1, 16)));
               else if (pick == 7)
                  write_reg(CSR_PAGE_SIZE, 17'd0);
               else if (pick == 8)
                  write_reg(CSR_PAGE_SIZE, 17'd256);
               else
                  write_reg(CSR_PAGE_SIZE, 17'($urandom_range(1, 256)));
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  write_reg(CSR_READ_LIMIT, 17'($urandom_range(0, 8)));
               else if (pick < 8)
                  write_reg(CSR_READ_LIMIT, 17'd65536);
               else
                  write_reg(CSR_READ_LIMIT, 17'($urandom_range(0, 65536)));
            end
         endcase
         csr_valid <= 1'b0;

         // One setting in the middle and the closing one run without any idling.
         idle_on = (s != 4) && (s != NUM_SETTINGS - 1);
         target = event_count + EVENTS_PER_SETTING;

         while (event_count < target) begin
            // Open a transfer: writes most often, then reads and verifies, now and then a bad mode.
            pick = $urandom_range(0, 99);
            mode = (pick < 40) ? MODE_WRITE : (pick < 70) ? MODE_READ :
                   (pick < 97) ? MODE_VERIFY : MODE_BAD;
            ev = any_event();
            ev.action = ACT_START;
            ev.mode   = mode;
            send_event(ev, 1'b0, none);
            if (mode == MODE_WRITE) write_count++;
            else if (mode == MODE_READ) read_count++;
            else if (mode == MODE_VERIFY) verify_count++;

            // Follow the transfer with well-formed bus events until it ends, with a little
            // noise mixed in: bus errors, restarts and events out of place.
            steps = 0;
            while (ee_phase != PH_IDLE && ee_phase != PH_ERR_XFER && ee_phase != PH_ERR_CMP
                   && steps < 400) begin
               ev = any_event();
               if ($urandom_range(0, 99) >= 4) begin
                  if (ee_phase == PH_READ) begin
                     ev.action  = ACT_SLAVE;
                     ev.rx_nack = ($urandom_range(0, 99) < 5);
                     if (ee_is_verify) begin
                        ev.tx_avail = ($urandom_range(0, 99) < 93);
                        if ($urandom_range(0, 99) < 94)
                           ev.tx_byte = ev.rx_byte;
                     end
                  end else begin
                     ev.action   = ACT_MASTER;
                     ev.arb_lost = ($urandom_range(0, 99) < 2);
                     ev.rx_nack  = ($urandom_range(0, 99) < 2);
                     ev.tx_avail = ($urandom_range(0, 99) < 93);
                  end
               end
               send_event(ev, 1'b0, none);
               steps++;
            end
         end
      end

      // Drain: everything owed must arrive, then a latency's worth of quiet for strays.
      req_tvalid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d bus events over %0d register settings after the directed table;",
               event_count, NUM_SETTINGS);
      $display("%0d writes, %0d reads and %0d verifies started, %0d replies compared.",
               write_count, read_count, verify_count, checked_count);
      if (fail_count == 0)
         $display("i2c_eeprom_transfer_sequencer verification clean");
      else
         $display("i2c_eeprom_transfer_sequencer verification failed");
      $finish;
   end

endmodule

FILE: i2c_eeprom_transfer_sequencer.f
sv/i2cee_pkg.sv
sv/i2cee_rem_unit.sv
sv/i2c_eeprom_transfer_sequencer.sv
tb/tb_i2c_eeprom_transfer_sequencer.sv
